// ===== hdl/rc4_pkg.sv =====
// Package for the RC4 stream cipher: widths, word types, the sequencer
// state type and the memory control bundle. No dependencies.
`default_nettype none

package rc4_pkg;

   // key store depth in bytes, 1 to 256
   localparam int KEY_DEPTH = 256;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   localparam int BOX_SIZE  = 256;
   localparam int BOX_AW    = 8;
   localparam int LEN_W     = 9;

   typedef logic [7:0]        byte_type;
   typedef logic [BOX_AW-1:0] box_addr_type;
   typedef logic [KEY_AW-1:0] key_addr_type;
   typedef logic [LEN_W-1:0]  len_type;

   localparam len_type KEY_LENGTH_RESET = len_type'(16);
   localparam len_type KEY_DEPTH_LEN    = len_type'(KEY_DEPTH);

   // request kinds
   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GEN_RD_I,
      ST_GEN_RD_J,
      ST_GEN_WR_J,
      ST_GEN_RD_T,
      ST_GEN_OUT,
      ST_KS_INIT,
      ST_KS_RD,
      ST_KS_ADD,
      ST_KS_SWAP,
      ST_KS_WR_J
   } seq_state_type;

   typedef struct packed {
      logic         box_we;
      box_addr_type box_waddr;
      byte_type     box_wdata;
      logic         box_re;
      box_addr_type box_raddr;
      logic         key_we;
      key_addr_type key_waddr;
      byte_type     key_wdata;
      logic         key_re;
      key_addr_type key_raddr;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/rc4_if.sv =====
// Channel interfaces of the RC4 stream cipher: request and response words.
// Depends on rc4_pkg.
`default_nettype none

interface rc4_req_if import rc4_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     req_type;
   byte_type byte_value;

   modport source (output valid, output req_type, output byte_value, input ready);
   modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type cipher_byte;
   byte_type keystream_byte;

   modport source (output valid, output cipher_byte, output keystream_byte, input ready);
   modport sink   (input valid, input cipher_byte, input keystream_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/rc4_stream_cipher.sv =====
// Top level of the RC4 stream cipher: S-box and key RAMs, sequencer and
// response register. Depends on rc4_pkg, rc4_if, rc4_ram and rc4_seq.
//
// Usage:
//   req_chan carries one word per request: req_type 0 stores byte_value as
//   the next key byte, req_type 1 enciphers byte_value. Key words give no
//   response; each data word gives one rsp_chan word with the cipher byte
//   and the keystream byte used.
//   csr_we/csr_wdata write key_length (0 acts as 1, above 256 acts as 256)
//   and restart key loading. Write it only while the block is idle.
//   When key_length key bytes have arrived, the S-box is rebuilt: an
//   identity fill of all 256 entries, then a read, add, swap and write
//   step per key schedule entry, all with req_chan.ready low.
//   Steps: a key word is written to the key store as it is accepted. A
//   data word runs read S[i], read S[j], two swap writes, read
//   S[S[i]+S[j]], then loads the response; no request is taken meanwhile.
//   Reset: synchronous, active high. Afterwards a clearing pass loads the
//   identity into all 256 S-box entries while req_chan.ready is low.
//   Stall: the response register holds its word until rsp_chan.ready; a
//   new request is still accepted, and the next response waits in the
//   sequencer until the register frees up.
`default_nettype none

module rc4_stream_cipher import rc4_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   rc4_req_if.sink    req_chan,
   rc4_rsp_if.source  rsp_chan,
   input  wire logic  csr_we,
   input  wire len_type csr_wdata
);

   mem_ctl_type mem_ctl;
   byte_type    box_rdata;
   byte_type    key_rdata;
   logic        res_free;
   logic        res_load;
   byte_type    res_cipher;
   byte_type    res_keystream;

   logic        rsp_valid_ff, rsp_valid_in;
   byte_type    cipher_ff, cipher_in;
   byte_type    keystream_ff, keystream_in;

   // S-box: 256 bytes, cleared to identity by the sequencer
   rc4_ram #(
      .WIDTH (8),
      .DEPTH (BOX_SIZE)
   ) u_box_ram (
      .clock (clock),
      .we    (mem_ctl.box_we),
      .waddr (mem_ctl.box_waddr),
      .wdata (mem_ctl.box_wdata),
      .re    (mem_ctl.box_re),
      .raddr (mem_ctl.box_raddr),
      .rdata (box_rdata)
   );

   // key store: only entries written in the current fill are read
   rc4_ram #(
      .WIDTH (8),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (mem_ctl.key_we),
      .waddr (mem_ctl.key_waddr),
      .wdata (mem_ctl.key_wdata),
      .re    (mem_ctl.key_re),
      .raddr (mem_ctl.key_raddr),
      .rdata (key_rdata)
   );

   rc4_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_kind      (req_chan.req_type),
      .req_byte      (req_chan.byte_value),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .mem_ctl       (mem_ctl),
      .box_rdata     (box_rdata),
      .key_rdata     (key_rdata),
      .res_free      (res_free),
      .res_load      (res_load),
      .res_cipher    (res_cipher),
      .res_keystream (res_keystream)
   );

   // response register: free when empty or being taken this cycle
   assign res_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cipher_in    = cipher_ff;
      keystream_in = keystream_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         cipher_in    = res_cipher;
         keystream_in = res_keystream;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff    <= cipher_in;
      keystream_ff <= keystream_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cipher_byte    = cipher_ff;
   assign rsp_chan.keystream_byte = keystream_ff;

endmodule

`default_nettype wire

// ===== hdl/rc4_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data held while read enable is low. No dependencies.
`default_nettype none

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic                                      re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/rc4_seq.sv =====
// Sequencer and shared byte adder of the RC4 cipher: clearing pass, key
// schedule and keystream generator over one S-box RAM. Depends on rc4_pkg.
`default_nettype none

module rc4_seq import rc4_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request side
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_kind,
   input  wire byte_type    req_byte,
   // key length register
   input  wire logic        csr_we,
   input  wire len_type     csr_wdata,
   // memories
   output      mem_ctl_type mem_ctl,
   input  wire byte_type    box_rdata,
   input  wire byte_type    key_rdata,
   // result register
   input  wire logic        res_free,
   output      logic        res_load,
   output      byte_type    res_cipher,
   output      byte_type    res_keystream
);

   seq_state_type state_ff, state_in;
   box_addr_type  k_ff, k_in;
   key_addr_type  kidx_ff, kidx_in;
   len_type       fill_ff, fill_in;
   len_type       key_length_ff, key_length_in;
   byte_type      i_ff, i_in;
   byte_type      j_ff, j_in;
   byte_type      hold_ff, hold_in;
   byte_type      data_ff, data_in;

   len_type       eff_len;
   len_type       fill_next;
   len_type       kidx_next;
   byte_type      add_base, add_op_a, add_op_b, add_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         k_ff          <= '0;
         kidx_ff       <= '0;
         fill_ff       <= '0;
         key_length_ff <= KEY_LENGTH_RESET;
         i_ff          <= '0;
         j_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         kidx_ff       <= kidx_in;
         fill_ff       <= fill_in;
         key_length_ff <= key_length_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      data_ff <= data_in;
   end

   // length saturated to 1..KEY_DEPTH
   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = len_type'(1);
      end else if (key_length_ff > KEY_DEPTH_LEN) begin
         eff_len = KEY_DEPTH_LEN;
      end else begin
         eff_len = key_length_ff;
      end
   end

   assign fill_next = fill_ff + len_type'(1);
   assign kidx_next = len_type'(kidx_ff) + len_type'(1);

   // the one shared adder: base + a + b, mod 256
   assign add_sum = add_base + add_op_a + add_op_b;

   assign res_cipher    = data_ff ^ box_rdata;
   assign res_keystream = box_rdata;

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      kidx_in       = kidx_ff;
      fill_in       = fill_ff;
      key_length_in = key_length_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      hold_in       = hold_ff;
      data_in       = data_ff;
      mem_ctl       = '0;
      req_ready     = 1'b0;
      res_load      = 1'b0;
      add_base      = j_ff;
      add_op_a      = box_rdata;
      add_op_b      = '0;

      unique case (state_ff)
         ST_CLEAR, ST_KS_INIT: begin
            mem_ctl.box_we    = 1'b1;
            mem_ctl.box_waddr = k_ff;
            mem_ctl.box_wdata = k_ff;
            k_in              = k_ff + box_addr_type'(1);
            if (k_ff == box_addr_type'(BOX_SIZE - 1)) begin
               if (state_ff == ST_CLEAR) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_KS_RD;
                  j_in     = '0;
                  kidx_in  = '0;
               end
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == REQ_DATA) begin
                  i_in              = i_ff + byte_type'(1);
                  data_in           = req_byte;
                  mem_ctl.box_re    = 1'b1;
                  mem_ctl.box_raddr = i_ff + byte_type'(1);
                  state_in          = ST_GEN_RD_I;
               end else begin
                  mem_ctl.key_we    = 1'b1;
                  mem_ctl.key_waddr = fill_ff[KEY_AW-1:0];
                  mem_ctl.key_wdata = req_byte;
                  if (fill_next >= eff_len) begin
                     fill_in  = '0;
                     k_in     = '0;
                     state_in = ST_KS_INIT;
                  end else begin
                     fill_in = fill_next;
                  end
               end
            end
         end
         // generator: j += S[i]
         ST_GEN_RD_I: begin
            hold_in           = box_rdata;
            j_in              = add_sum;
            mem_ctl.box_re    = 1'b1;
            mem_ctl.box_raddr = add_sum;
            state_in          = ST_GEN_RD_J;
         end
         ST_GEN_RD_J: begin
            mem_ctl.box_we    = 1'b1;
            mem_ctl.box_waddr = i_ff;
            mem_ctl.box_wdata = box_rdata;
            state_in          = ST_GEN_WR_J;
         end
         ST_GEN_WR_J: begin
            mem_ctl.box_we    = 1'b1;
            mem_ctl.box_waddr = j_ff;
            mem_ctl.box_wdata = hold_ff;
            state_in          = ST_GEN_RD_T;
         end
         // read data still holds old S[j]; S[i] + S[j] is swap invariant
         ST_GEN_RD_T: begin
            add_base          = '0;
            add_op_b          = hold_ff;
            mem_ctl.box_re    = 1'b1;
            mem_ctl.box_raddr = add_sum;
            state_in          = ST_GEN_OUT;
         end
         ST_GEN_OUT: begin
            if (res_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         // key schedule
         ST_KS_RD: begin
            mem_ctl.box_re    = 1'b1;
            mem_ctl.box_raddr = k_ff;
            mem_ctl.key_re    = 1'b1;
            mem_ctl.key_raddr = kidx_ff;
            state_in          = ST_KS_ADD;
         end
         ST_KS_ADD: begin
            add_op_b          = key_rdata;
            hold_in           = box_rdata;
            j_in              = add_sum;
            mem_ctl.box_re    = 1'b1;
            mem_ctl.box_raddr = add_sum;
            state_in          = ST_KS_SWAP;
         end
         ST_KS_SWAP: begin
            mem_ctl.box_we    = 1'b1;
            mem_ctl.box_waddr = k_ff;
            mem_ctl.box_wdata = box_rdata;
            state_in          = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            mem_ctl.box_we    = 1'b1;
            mem_ctl.box_waddr = j_ff;
            mem_ctl.box_wdata = hold_ff;
            k_in              = k_ff + box_addr_type'(1);
            if (kidx_next >= eff_len) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_next[KEY_AW-1:0];
            end
            if (k_ff == box_addr_type'(BOX_SIZE - 1)) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         key_length_in = csr_wdata;
         fill_in       = '0;
      end
   end

endmodule

`default_nettype wire
